### rtl/vsmc_pkg.sv
// Shared types, constants and byte functions of the Vigenere, ShiftRows and MixColumns cipher.
`default_nettype none
package vsmc_pkg;

  localparam int unsigned BlockBytes = 16;
  localparam int unsigned KeyMax     = 16;

  localparam logic [7:0] PadChar   = 8'd65;
  localparam logic [7:0] GfReduce  = 8'h1B;
  localparam logic [4:0] FillFull  = 5'd16;
  localparam logic [4:0] KeyMaxLen = 5'(KeyMax);

  // Configuration register indexes.
  localparam logic [1:0] RegKeyLow    = 2'd0;
  localparam logic [1:0] RegKeyHigh   = 2'd1;
  localparam logic [1:0] RegKeyLength = 2'd2;

  localparam logic [63:0] KeyCharsReset = 64'h4141_4141_4141_4141;

  typedef logic [7:0]                  byte_t;
  typedef logic [BlockBytes-1:0][7:0]  block_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  // Whitespace and punctuation are removed from the stream.
  function automatic logic is_dropped(input logic [6:0] b);
    logic drop;
    drop = ((b >= 7'd9) && (b <= 7'd13)) || (b == 7'd32) ||
           ((b >= 7'd33) && (b <= 7'd47)) || ((b >= 7'd58) && (b <= 7'd64)) ||
           ((b >= 7'd91) && (b <= 7'd96)) || ((b >= 7'd123) && (b <= 7'd126));
    return drop;
  endfunction

  function automatic byte_t key_byte(input logic [63:0] lo, input logic [63:0] hi,
                                     input logic [3:0] pos);
    logic [63:0] word;
    word = pos[3] ? hi : lo;
    return word[{pos[2:0], 3'b000} +: 8];
  endfunction

  // Key length with zero taken as one and large values clamped.
  function automatic logic [4:0] effective_length(input logic [4:0] len);
    logic [4:0] l;
    l = len;
    if (l == 5'd0) begin
      l = 5'd1;
    end
    if (l > KeyMaxLen) begin
      l = KeyMaxLen;
    end
    return l;
  endfunction

  // Vigenere step. The remainder keeps the sign of the sum; the magnitude is at
  // most 252, so a multiply by 79 and a shift by 11 gives the exact quotient by 26.
  function automatic byte_t vig_sub(input logic [6:0] b, input byte_t k);
    logic signed [9:0] sum;
    logic [7:0]        mag;
    logic [14:0]       prod;
    logic [3:0]        quot;
    logic [4:0]        rem;
    sum  = $signed({3'b000, b}) + $signed({2'b00, k}) - 10'sd130;
    mag  = sum[9] ? 8'(-sum) : 8'(sum);
    prod = 15'(mag) * 15'd79;
    quot = prod[14:11];
    rem  = 5'(mag - 8'(quot) * 8'd26);
    return sum[9] ? (8'd65 - 8'(rem)) : (8'd65 + 8'(rem));
  endfunction

  function automatic byte_t xtime(input byte_t x);
    byte_t y;
    y = {x[6:0], 1'b0};
    if (x[7]) begin
      y = y ^ GfReduce;
    end
    return y;
  endfunction

  // ShiftRows, parity into bit 7, then MixColumns over the whole block.
  function automatic block_t mix_block(input block_t b);
    block_t     s;
    block_t     m;
    logic [1:0] cc;
    byte_t      v;
    byte_t      a0;
    byte_t      a1;
    byte_t      a2;
    byte_t      a3;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        cc = 2'(c + r);
        v  = b[r * 4 + int'(cc)];
        s[r * 4 + c] = {^v[6:0], v[6:0]};
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = s[c];
      a1 = s[c + 4];
      a2 = s[c + 8];
      a3 = s[c + 12];
      m[c]      = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      m[c + 4]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      m[c + 8]  = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      m[c + 12] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

### rtl/vigenere_shiftrows_mixcolumns_cipher_core.sv
// Top level of the Vigenere, ShiftRows and MixColumns cipher core.
// The core takes 7-bit text characters, drops whitespace and punctuation, passes every
// remaining character through a Vigenere step with a rotating key of up to sixteen
// characters, and gathers the results into 16-byte blocks. Each finished block passes
// through ShiftRows, a parity bit in bit 7 and MixColumns, and leaves as sixteen
// transfers in index order, with block_last on the sixteenth and message_last on the
// sixteenth of the message's final block. A message_end on a partly filled block pads
// it with 'A'. Storage is two rows of sixteen byte cells: the collect row, into which
// each kept character shifts at one end, and the output row, which is loaded with the
// whole processed block at once and shifts one byte out per output transfer. The
// collect row fills while the output row drains the previous block. Once the collect
// row holds sixteen bytes the input stalls until the output row is empty, and also in
// the cycle in which the block moves across; the first output transfer of the block
// is offered in the cycle after that. With an output side that never stalls, the
// input sustains close to one character per cycle; a stalling receiver slows it to
// the pace of the sixteen output transfers per block. Padding a partial block shifts
// pad bytes into the collect row while the input stalls, followed by the same move
// to the output row. Configuration writes are always ready and take effect at the
// next clock edge; they should only be made while the core is idle.
`default_nettype none
module vigenere_shiftrows_mixcolumns_cipher_core
  import vsmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Text input.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [6:0]  text_byte,
  input  logic        message_end,
  // Cipher output.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  cipher_byte,
  output logic        block_last,
  output logic        message_last,
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // Key registers.
  logic [63:0] key_chars_low;
  logic [63:0] key_chars_high;
  logic [4:0]  key_length;

  // Collect side: number of bytes in the collect row (sixteen means a block waits),
  // padding in progress, and whether the waiting block ends the message.
  logic [4:0] fill;
  logic [4:0] fill_next;
  logic       pad_mode;
  logic       pad_mode_next;
  logic       final_pending;
  logic       final_pending_next;
  logic [3:0] key_position;
  logic [3:0] key_position_next;

  // Output side: bytes still to be transferred and the message flag of that block.
  logic [4:0] out_left;
  logic [4:0] out_left_next;
  logic       out_final;
  logic       out_final_next;

  logic       in_accept;
  logic       out_accept;
  logic       kept;
  logic       block_full;
  logic       handoff;
  logic [4:0] fill_after;
  logic [4:0] eff_len;
  byte_t      collect_in;
  block_t     collect_data;
  block_t     out_data;
  block_t     mixed;
  cell_ctl_t  collect_ctl;
  cell_ctl_t  out_ctl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_chars_low  <= KeyCharsReset;
      key_chars_high <= KeyCharsReset;
      key_length     <= 5'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegKeyLow:    key_chars_low  <= cfg_data;
        RegKeyHigh:   key_chars_high <= cfg_data;
        RegKeyLength: key_length     <= cfg_data[4:0];
        default:      ;
      endcase
    end
  end

  assign block_full = (fill == FillFull);
  assign in_stall   = pad_mode || block_full;
  assign in_accept  = in_valid && !in_stall;
  assign kept       = !is_dropped(text_byte);
  assign eff_len    = effective_length(key_length);
  assign fill_after = (in_accept && kept) ? (fill + 5'd1) : fill;

  // The waiting block moves to the output row only once that row is empty.
  assign handoff    = block_full && (out_left == 5'd0);

  assign out_valid    = (out_left != 5'd0);
  assign out_accept   = out_valid && !out_stall;
  assign cipher_byte  = out_data[0];
  assign block_last   = (out_left == 5'd1);
  assign message_last = block_last && out_final;

  assign collect_in = pad_mode ? PadChar
                               : vig_sub(text_byte,
                                         key_byte(key_chars_low, key_chars_high, key_position));

  always_comb begin
    fill_next          = fill;
    pad_mode_next      = pad_mode;
    final_pending_next = final_pending;
    key_position_next  = key_position;
    if (handoff) begin
      fill_next = 5'd0;
    end
    if (pad_mode) begin
      fill_next = fill + 5'd1;
      if (fill + 5'd1 == FillFull) begin
        pad_mode_next = 1'b0;
      end
    end
    if (in_accept) begin
      fill_next = fill_after;
      if (kept) begin
        if ({1'b0, key_position} + 5'd1 >= eff_len) begin
          key_position_next = 4'd0;
        end else begin
          key_position_next = key_position + 4'd1;
        end
      end
      if (message_end) begin
        key_position_next  = 4'd0;
        final_pending_next = 1'b1;
        if ((fill_after != 5'd0) && (fill_after != FillFull)) begin
          pad_mode_next = 1'b1;
        end
      end else begin
        final_pending_next = 1'b0;
      end
    end
  end

  always_comb begin
    out_left_next  = out_left;
    out_final_next = out_final;
    if (handoff) begin
      out_left_next  = FillFull;
      out_final_next = final_pending;
    end else if (out_accept) begin
      out_left_next = out_left - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= 5'd0;
      pad_mode      <= 1'b0;
      final_pending <= 1'b0;
      key_position  <= 4'd0;
      out_left      <= 5'd0;
      out_final     <= 1'b0;
    end else begin
      fill          <= fill_next;
      pad_mode      <= pad_mode_next;
      final_pending <= final_pending_next;
      key_position  <= key_position_next;
      out_left      <= out_left_next;
      out_final     <= out_final_next;
    end
  end

  assign collect_ctl.load  = 1'b0;
  assign collect_ctl.shift = (in_accept && kept) || pad_mode;
  assign out_ctl.load      = handoff;
  assign out_ctl.shift     = out_accept;

  assign mixed = mix_block(collect_data);

  // New bytes enter the collect row at cell 15 and move towards cell 0, so after
  // sixteen steps cell i holds block byte i. The output row drains from cell 0.
  for (genvar i = 0; i < BlockBytes; i++) begin : g_cells
    byte_t collect_shift_in;
    byte_t out_shift_in;
    if (i == BlockBytes - 1) begin : g_end
      assign collect_shift_in = collect_in;
      assign out_shift_in     = '0;
    end else begin : g_mid
      assign collect_shift_in = collect_data[i + 1];
      assign out_shift_in     = out_data[i + 1];
    end

    vsmc_cell u_collect_cell (
      .clk       (clk),
      .ctl       (collect_ctl),
      .load_data (collect_in),
      .shift_in  (collect_shift_in),
      .data      (collect_data[i])
    );

    vsmc_cell u_out_cell (
      .clk       (clk),
      .ctl       (out_ctl),
      .load_data (mixed[i]),
      .shift_in  (out_shift_in),
      .data      (out_data[i])
    );
  end

endmodule
`default_nettype wire

### rtl/vsmc_cell.sv
// One byte cell of a shift row: parallel load or a step from its neighbour.
`default_nettype none
module vsmc_cell
  import vsmc_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  byte_t     load_data,
  input  byte_t     shift_in,
  output byte_t     data
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data <= load_data;
    end else if (ctl.shift) begin
      data <= shift_in;
    end
  end

endmodule
`default_nettype wire

### rtl/vsmc_checker.sv
// Port-level assertions for the cipher core, bound to its top level.
`default_nettype none
module vsmc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] cipher_byte,
  input logic       block_last,
  input logic       message_last
);

  // After reset nothing is pending on either side.
  a_reset_quiet: assert property (@(posedge clk) rst |=> (!out_valid && !in_stall))
    else $error("core not quiet after reset");

  // The message flag only ever marks the end of a block.
  a_msg_on_block_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && message_last) |-> block_last)
    else $error("message_last without block_last");

  // A block leaves without gaps: a transfer other than the last is followed by a valid byte.
  a_block_contiguous: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !block_last) |=> out_valid)
    else $error("gap inside an output block");

  // A stalled output byte is held.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(cipher_byte)))
    else $error("stalled output changed");

endmodule

bind vigenere_shiftrows_mixcolumns_cipher_core vsmc_checker u_vsmc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .cipher_byte  (cipher_byte),
  .block_last   (block_last),
  .message_last (message_last)
);
`default_nettype wire
